// ===== rtl/polyphase_4x4_upsample_conv_assert.svh =====
`ifndef POLYPHASE_4X4_UPSAMPLE_CONV_ASSERT_SVH
`define POLYPHASE_4X4_UPSAMPLE_CONV_ASSERT_SVH

// same-cycle implication, off during reset
`define PUC_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("puc check failed");

// next-cycle implication, off during reset
`define PUC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("puc check failed");

// next-cycle implication that also holds across reset
`define PUC_ASSERT_ALWAYS(lbl, clk, a, b) \
    lbl: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("puc check failed");

`endif

// ===== rtl/puc_pkg.sv =====
package puc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int KERNEL_SIDE = 4;
    localparam int LINES       = KERNEL_SIDE - 1;
    localparam int TAPS        = KERNEL_SIDE * KERNEL_SIDE;
    localparam int PHASES      = 4;
    localparam int COEF_SLOTS  = PHASES * TAPS;

    localparam int DIM_W    = 11;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int POS_W    = 10;
    localparam int IDX_W    = 6;
    localparam int SMP_W    = 16;
    localparam int OUT_W    = 24;
    localparam int LINE_W   = LINES * SMP_W;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 120;

    localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(4);
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1024);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1024);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic {
        KIND_COEF   = 1'b0,
        KIND_SAMPLE = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  coef_index;
        logic [SMP_W-1:0]  coef_value;
        logic [SMP_W-1:0]  sample;
    } t_item;

    typedef struct packed {
        logic [PHASES-1:0][OUT_W-1:0] sums;
        logic [POS_W-1:0]             window_row;
        logic [POS_W-1:0]             window_col;
        logic                         last_of_frame;
    } t_result;

    typedef struct packed {
        logic             restart;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_geom;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ===== rtl/puc_front.sv =====
module puc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // coef_index[5:0], coef_value[21:6], sample[37:22], zero pad
    input  logic [puc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // func[0]
    input  logic                              i_s_axis_tuser,
    output logic                              o_valid,
    input  logic                              i_ready,
    output puc_pkg::t_item                    o_item
);
    import puc_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_s_axis_tready = !r_valid || i_ready;
    assign o_valid         = r_valid;
    assign o_item          = r_item;

    always_comb begin
        n_item.kind       = i_s_axis_tuser ? KIND_SAMPLE : KIND_COEF;
        n_item.coef_index = i_s_axis_tdata[IDX_W-1:0];
        n_item.coef_value = i_s_axis_tdata[IDX_W+SMP_W-1:IDX_W];
        n_item.sample     = i_s_axis_tdata[IDX_W+2*SMP_W-1:IDX_W+SMP_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/puc_queue.sv =====
module puc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  puc_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_valid,
    output puc_pkg::t_item o_item
);
    import puc_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W:0]     r_count;
    logic               do_push;
    logic               do_pop;

    assign o_ready = r_count != (PTR_W+1)'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== rtl/puc_back.sv =====
module puc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  puc_pkg::t_geom   i_geom,
    input  logic             i_valid,
    output logic             o_pop,
    input  puc_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output puc_pkg::t_result o_result
);
    import puc_pkg::*;

    localparam int PROD_W = 2 * SMP_W;
    localparam int PART_W = PROD_W + 2;
    localparam int ACC_W  = PROD_W + 4;
    localparam int GROUPS = TAPS / KERNEL_SIDE;

    typedef struct packed {
        logic             res;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_meta;

    logic en;

    // position counters
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] r_cur;
    logic [DIM_W-1:0] c_inc;
    logic [DIM_W-1:0] r_inc;
    logic             is_sample;
    t_meta            meta0;

    // stage 1
    logic             r_s1_valid;
    t_item            r_s1_item;
    logic [COL_W-1:0] r_s1_addr;
    t_meta            r_s1_meta;
    logic [LINE_W-1:0] r_rd;
    logic [LINE_W-1:0] r_line [MAX_WIDTH];
    logic [KERNEL_SIDE-1:0][SMP_W-1:0] col_new;

    // stage 2
    logic             r_s2_valid;
    t_item            r_s2_item;
    t_meta            r_s2_meta;
    logic [SMP_W-1:0] r_win  [KERNEL_SIDE][KERNEL_SIDE];
    logic [SMP_W-1:0] r_coef [COEF_SLOTS];

    // stages 3 to 5
    logic signed [PROD_W-1:0] r_prod [PHASES][TAPS];
    logic signed [PART_W-1:0] r_part [PHASES][GROUPS];
    logic signed [ACC_W-1:0]  r_acc  [PHASES];
    t_meta r_s3_meta;
    t_meta r_s4_meta;
    t_meta r_s5_meta;

    logic    r_out_valid;
    t_result r_out;
    logic [PHASES-1:0][OUT_W-1:0] rounded;

    function automatic logic [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] t;
        logic signed [ACC_W:0] q;
        logic [OUT_W-1:0]      r;
        t = (ACC_W+1)'(a) + (ACC_W+1)'(2048);
        q = t >>> 12;
        if (q > (ACC_W+1)'(8388607)) begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (q < -(ACC_W+1)'(8388608)) begin
            r = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            r = q[OUT_W-1:0];
        end
        return r;
    endfunction

    assign en        = !r_out_valid || i_ready;
    assign o_pop     = en && i_valid;
    assign is_sample = i_item.kind == KIND_SAMPLE;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        c_cur = ({1'b0, r_col} >= i_geom.width)  ? '0 : r_col;
        r_cur = ({1'b0, r_row} >= i_geom.height) ? '0 : r_row;
        c_inc = {1'b0, c_cur} + 1'b1;
        r_inc = {1'b0, r_cur} + 1'b1;
        meta0.res  = o_pop && is_sample
            && (r_cur >= ROW_W'(LINES)) && (c_cur >= COL_W'(LINES));
        meta0.row  = POS_W'(r_cur - ROW_W'(LINES));
        meta0.col  = POS_W'(c_cur - COL_W'(LINES));
        meta0.last = (r_inc == i_geom.height) && (c_inc == i_geom.width);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_geom.restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_pop && is_sample) begin
            if (c_inc >= i_geom.width) begin
                r_col <= '0;
                r_row <= (r_inc >= i_geom.height) ? '0 : r_inc[ROW_W-1:0];
            end else begin
                r_col <= c_inc[COL_W-1:0];
                r_row <= r_cur;
            end
        end
    end

    // line store read, then write-back from the stage 1 registers
    always_ff @(posedge i_clk) begin
        if (o_pop && is_sample) begin
            r_rd <= r_line[c_cur];
        end
        if (en && r_s1_valid && r_s1_item.kind == KIND_SAMPLE) begin
            r_line[r_s1_addr] <= {r_s1_item.sample, r_rd[LINE_W-1:SMP_W]};
        end
    end

    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            col_new[i] = r_rd[i*SMP_W +: SMP_W];
        end
        col_new[LINES] = r_s1_item.sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_meta   <= '0;
            r_s4_meta   <= '0;
            r_s5_meta   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < KERNEL_SIDE; i++) begin
                for (int j = 0; j < KERNEL_SIDE; j++) begin
                    r_win[i][j] <= '0;
                end
            end
            for (int k = 0; k < COEF_SLOTS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (en) begin
            r_s1_valid  <= o_pop;
            r_s2_valid  <= r_s1_valid;
            r_s3_meta   <= r_s2_meta;
            r_s4_meta   <= r_s3_meta;
            r_s5_meta   <= r_s4_meta;
            r_out_valid <= r_s5_meta.res;
            if (r_s1_valid && r_s1_item.kind == KIND_SAMPLE) begin
                for (int i = 0; i < KERNEL_SIDE; i++) begin
                    for (int j = 0; j < KERNEL_SIDE - 1; j++) begin
                        r_win[i][j] <= r_win[i][j+1];
                    end
                    r_win[i][KERNEL_SIDE-1] <= col_new[i];
                end
            end
            if (r_s2_valid && r_s2_item.kind == KIND_COEF) begin
                r_coef[r_s2_item.coef_index] <= r_s2_item.coef_value;
            end
        end
    end

    always_comb begin
        for (int p = 0; p < PHASES; p++) begin
            rounded[p] = round_sat(r_acc[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_item <= i_item;
            r_s1_addr <= c_cur;
            r_s1_meta <= meta0;
            r_s2_item <= r_s1_item;
            r_s2_meta <= r_s1_meta;
            for (int p = 0; p < PHASES; p++) begin
                for (int k = 0; k < TAPS; k++) begin
                    r_prod[p][k] <= $signed(r_coef[p*TAPS+k])
                        * $signed(r_win[k/KERNEL_SIDE][k%KERNEL_SIDE]);
                end
                for (int g = 0; g < GROUPS; g++) begin
                    r_part[p][g] <= PART_W'(r_prod[p][g*KERNEL_SIDE])
                        + PART_W'(r_prod[p][g*KERNEL_SIDE+1])
                        + PART_W'(r_prod[p][g*KERNEL_SIDE+2])
                        + PART_W'(r_prod[p][g*KERNEL_SIDE+3]);
                end
                r_acc[p] <= ACC_W'(r_part[p][0]) + ACC_W'(r_part[p][1])
                    + ACC_W'(r_part[p][2]) + ACC_W'(r_part[p][3]);
            end
            r_out.sums          <= rounded;
            r_out.window_row    <= r_s5_meta.row;
            r_out.window_col    <= r_s5_meta.col;
            r_out.last_of_frame <= r_s5_meta.last;
        end
    end

endmodule

// ===== rtl/polyphase_4x4_upsample_conv.sv =====
// polyphase 2x upsampling convolution, 4x4 window
// input stream: one item per transfer; tuser=1 carries an image sample in
// raster order, tuser=0 loads one of the 64 coefficients (slot in coef_index)
// output stream: one transfer per full 4x4 window, holding the four phase
// outputs (rounded off 12 fraction bits, saturated) plus window row and column;
// tlast marks the last window of the frame
// apb port: image_width at 0x0, image_height at 0x4; a write restarts the frame
// throughput: one input item per clock while the receiver does not stall, set by
// the line store (one read and one write per cycle, 1024 x 48 bits)
// path: from input transfer to output valid, after the input register come the
// queue, line store read, window, multiply, two adder levels, and round/saturate
// into the output register
// reset clears coefficients, window, counters and all valid flags; line
// store contents stay undefined until written
// when the receiver stalls, the back pipeline freezes, the queue fills and
// tready drops after the queue and input register are full
module polyphase_4x4_upsample_conv (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // coef_index[5:0], coef_value[21:6], sample[37:22], zero pad
    input  logic [puc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // func[0]
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // out_top_left[23:0], out_top_right[47:24], out_bottom_left[71:48],
    // out_bottom_right[95:72], window_row[105:96], window_col[115:106], zero pad
    output logic [puc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [2:0]                         i_paddr,
    input  logic [31:0]                        i_pwdata,
    output logic [31:0]                        o_prdata,
    output logic                               o_pready
);
    import puc_pkg::*;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             r_restart;
    logic             cfg_wr;
    t_geom            geom;

    logic    f_valid;
    logic    q_ready;
    t_item   f_item;
    logic    q_valid;
    logic    b_pop;
    t_item   q_item;
    t_result res;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_prdata = (i_paddr[2] == REG_HEIGHT) ? 32'(r_height) : 32'(r_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_restart <= 1'b0;
        end else begin
            r_restart <= cfg_wr;
            if (cfg_wr) begin
                if (i_paddr[2] == REG_WIDTH) begin
                    r_width <= i_pwdata[DIM_W-1:0];
                end else begin
                    r_height <= i_pwdata[DIM_W-1:0];
                end
            end
        end
    end

    always_comb begin
        geom.restart = r_restart;
        geom.width   = clamp_dim(r_width, DIM_W'(MAX_WIDTH));
        geom.height  = clamp_dim(r_height, DIM_W'(MAX_HEIGHT));
    end

    puc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_valid         (f_valid),
        .i_ready         (q_ready),
        .o_item          (f_item)
    );

    puc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .i_item  (f_item),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    puc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_geom   (geom),
        .i_valid  (q_valid),
        .o_pop    (b_pop),
        .i_item   (q_item),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (res)
    );

    assign o_m_axis_tdata = {4'b0, res.window_col, res.window_row,
                             res.sums[3], res.sums[2], res.sums[1], res.sums[0]};
    assign o_m_axis_tlast = res.last_of_frame;

endmodule

// ===== rtl/puc_checker.sv =====
`include "polyphase_4x4_upsample_conv_assert.svh"

module puc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [puc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);
    import puc_pkg::*;

    logic stalled;
    logic pos_ok;

    assign stalled = o_m_axis_tvalid && !i_m_axis_tready;
    assign pos_ok  = (o_m_axis_tdata[105:96] <= 10'd1020)
        && (o_m_axis_tdata[115:106] <= 10'd1020)
        && (o_m_axis_tdata[119:116] == 4'd0);

    `PUC_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, stalled, o_m_axis_tvalid)
    `PUC_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, stalled, $stable(o_m_axis_tdata))
    `PUC_ASSERT_NEXT(a_hold_last, i_clk, i_rst_n, stalled, $stable(o_m_axis_tlast))
    `PUC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_m_axis_tvalid)
    `PUC_ASSERT_IMPLY(a_pos_range, i_clk, i_rst_n, o_m_axis_tvalid, pos_ok)

endmodule

bind polyphase_4x4_upsample_conv puc_checker u_puc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== sim/upsample_conv_checker.sv =====
`timescale 1ns / 100ps

module upsample_conv_checker
    import puc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // coef_index[5:0], coef_value[21:6], sample[37:22], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // func[0]
    input  logic                   i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // four phase sums[95:0], window_row[105:96], window_col[115:106], zero pad
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tlast,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_pready,
    input  logic [2:0]             i_paddr,
    input  logic [31:0]            i_pwdata,
    output int                     o_fail_count,
    output int                     o_pending
);

    logic [SMP_W-1:0] coef_mem [COEF_SLOTS];
    logic [SMP_W-1:0] line_mem [LINES][MAX_WIDTH];
    logic [SMP_W-1:0] win [TAPS];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    t_result          window_q [$];
    int               fails;

    function automatic int unsigned bound_dim(logic [DIM_W-1:0] v, int unsigned hi);
        int unsigned d;
        d = v;
        if (d < 4) begin
            d = 4;
        end else if (d > hi) begin
            d = hi;
        end
        return d;
    endfunction

    function automatic logic [OUT_W-1:0] phase_out(int p);
        longint acc;
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'($signed(coef_mem[p*TAPS+k])) * longint'($signed(win[k]));
        end
        acc = (acc + 2048) >>> 12;
        if (acc > 64'sd8388607) begin
            acc = 64'sd8388607;
        end else if (acc < -64'sd8388608) begin
            acc = -64'sd8388608;
        end
        return acc[OUT_W-1:0];
    endfunction

    task automatic absorb_sample(logic [SMP_W-1:0] smp);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic [SMP_W-1:0] column [KERNEL_SIDE];
        t_result          res;
        w = bound_dim(width_reg, MAX_WIDTH);
        h = bound_dim(height_reg, MAX_HEIGHT);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        for (int i = 0; i < LINES; i++) begin
            column[i] = line_mem[i][c];
        end
        column[LINES] = smp;
        for (int i = 0; i < LINES; i++) begin
            line_mem[i][c] = column[i+1];
        end
        for (int i = 0; i < KERNEL_SIDE; i++) begin
            for (int j = 0; j < KERNEL_SIDE - 1; j++) begin
                win[i*KERNEL_SIDE+j] = win[i*KERNEL_SIDE+j+1];
            end
            win[i*KERNEL_SIDE+KERNEL_SIDE-1] = column[i];
        end
        if (r >= LINES && c >= LINES) begin
            for (int p = 0; p < PHASES; p++) begin
                res.sums[p] = phase_out(p);
            end
            res.window_row    = POS_W'(r - LINES);
            res.window_col    = POS_W'(c - LINES);
            res.last_of_frame = (r + 1 == h) && (c + 1 == w);
            window_q.push_back(res);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic check_window();
        t_result exp_r;
        t_result got;
        got.sums          = i_m_tdata[PHASES*OUT_W-1:0];
        got.window_row    = i_m_tdata[PHASES*OUT_W +: POS_W];
        got.window_col    = i_m_tdata[PHASES*OUT_W+POS_W +: POS_W];
        got.last_of_frame = i_m_tlast;
        if (window_q.size() == 0) begin
            $display("%0t unexpected window: got %h", $time, got);
            fails++;
            return;
        end
        exp_r = window_q.pop_front();
        for (int p = 0; p < PHASES; p++) begin
            if (got.sums[p] !== exp_r.sums[p]) begin
                $display("%0t phase %0d sum: expected %h actual %h",
                         $time, p, exp_r.sums[p], got.sums[p]);
                fails++;
            end
        end
        if (got.window_row !== exp_r.window_row) begin
            $display("%0t window_row: expected %0d actual %0d",
                     $time, exp_r.window_row, got.window_row);
            fails++;
        end
        if (got.window_col !== exp_r.window_col) begin
            $display("%0t window_col: expected %0d actual %0d",
                     $time, exp_r.window_col, got.window_col);
            fails++;
        end
        if (got.last_of_frame !== exp_r.last_of_frame) begin
            $display("%0t last_of_frame: expected %b actual %b",
                     $time, exp_r.last_of_frame, got.last_of_frame);
            fails++;
        end
    endtask

    initial begin
        fails = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < COEF_SLOTS; k++) begin
                coef_mem[k] = '0;
            end
            for (int k = 0; k < TAPS; k++) begin
                win[k] = '0;
            end
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            window_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_window();
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_HEIGHT) begin
                    height_reg = i_pwdata[DIM_W-1:0];
                end else begin
                    width_reg = i_pwdata[DIM_W-1:0];
                end
                col_pos = 0;
                row_pos = 0;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (t_kind'(i_s_tuser) == KIND_COEF) begin
                    coef_mem[i_s_tdata[IDX_W-1:0]] = i_s_tdata[IDX_W +: SMP_W];
                end else begin
                    absorb_sample(i_s_tdata[IDX_W+SMP_W +: SMP_W]);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= window_q.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import puc_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    int                     fail_count;
    int                     pending;
    int                     idle_cycles = 0;
    int                     stall_left = 0;
    int                     calm_left = 0;
    int                     items_sent = 0;

    always #1 i_clk = ~i_clk;

    polyphase_4x4_upsample_conv i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready)
    );

    upsample_conv_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stalls: single-cycle noise, short and long stalls, calm stretches
    always @(posedge i_clk) begin
        int pick;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
            m_tready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                m_tready <= 1'b1;
            end else if (pick < 88) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else if (pick < 94) begin
                stall_left = $urandom_range(10, 40);
                m_tready <= 1'b0;
            end else begin
                calm_left = $urandom_range(50, 200);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("polyphase_4x4_upsample_conv: mismatch");
                $finish;
            end
        end
    end

    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SMP_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    task automatic push_item(t_kind kind, logic [IDX_W-1:0] idx,
                             logic [SMP_W-1:0] val, logic [SMP_W-1:0] smp);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, smp, val, idx};
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        items_sent++;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_coef(logic [IDX_W-1:0] idx, logic [SMP_W-1:0] val);
        push_item(KIND_COEF, idx, val, SMP_W'($urandom));
    endtask

    task automatic push_sample(logic [SMP_W-1:0] smp);
        push_item(KIND_SAMPLE, IDX_W'($urandom), SMP_W'($urandom), smp);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic sel, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sel ? 3'd4 : 3'd0;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(int w_val, int h_val, int samples);
        write_reg(REG_WIDTH, w_val);
        write_reg(REG_HEIGHT, h_val);
        for (int n = 0; n < samples; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                load_coef(IDX_W'($urandom), pick_value());
            end
            push_sample(pick_value());
        end
        drain();
    endtask

    initial begin
        int w;
        int h;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme coefficients and samples in a 4x4 frame
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 4);
        load_coef(6'd0, 16'h8000);
        load_coef(6'd63, 16'h7fff);
        load_coef(6'd21, 16'hffff);
        load_coef(6'd42, 16'h0001);
        for (int n = 0; n < 16; n++) begin
            case (n % 4)
                0: push_sample(16'h8000);
                1: push_sample(16'h7fff);
                2: push_sample(16'hffff);
                default: push_sample(16'h0000);
            endcase
        end
        drain();

        for (int k = 0; k < COEF_SLOTS; k++) begin
            load_coef(IDX_W'(k), SMP_W'($urandom));
        end
        drain();

        // out-of-range register values clamp to the limits
        run_phase(2047, 3, 40);
        run_phase(0, 2047, 4 * 40);

        while (items_sent < 1300) begin
            w = $urandom_range(4, 9);
            h = $urandom_range(4, 8);
            run_phase(w, h, w * h * $urandom_range(1, 2) + $urandom_range(0, 1) * w);
        end

        drain();
        if (fail_count == 0) begin
            $display("polyphase_4x4_upsample_conv: match");
        end else begin
            $display("polyphase_4x4_upsample_conv: mismatch");
        end
        $finish;
    end

endmodule
